@@ hdl/smpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// smpwm_pkg
// Shared widths, codes and beat types of the staggered multichannel PWM.
// ----------------------------------------------------------------------------
package smpwm_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int POS_W    = 24;
  localparam int STEP_W   = 16;
  localparam int WIDTH_W  = 24;
  localparam int PINS_W   = 8;
  localparam int MODE_W   = 2;
  localparam int CHAN_W   = 3;
  localparam int VALUE_W  = 24;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;
  localparam int REG_IDX_W  = 1;
  localparam int REG_DATA_W = 24;
  // start/stop of a window: rank * step plus a full width
  localparam int EDGE_W = ((STEP_W + CH_W) > WIDTH_W ? STEP_W + CH_W : WIDTH_W) + 1;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WIDTH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MASK  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_STAGGER_STEP = 1'd1;

  localparam logic [POS_W-1:0]   RESET_PERIOD = 24'd1600000;
  localparam logic [STEP_W-1:0]  RESET_STEP   = 16'd200;
  localparam logic [WIDTH_W-1:0] RESET_WIDTH  = 24'd200000;

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [CH_W-1:0]    rank_t;

  // item as it leaves the frame counter
  typedef struct packed {
    logic             valid;
    logic             tick;
    logic             fs;
    logic [POS_W-1:0] pos;
  } head_t;

  // window of one channel for the frame being started
  typedef struct packed {
    logic              en;
    logic [EDGE_W-1:0] start;
    logic [EDGE_W-1:0] stop;
  } frame_t;

  // beat that walks down the channel cells
  typedef struct packed {
    logic                         valid;
    logic                         tick;
    logic                         fs;
    logic [POS_W-1:0]             pos;
    logic [CHANNELS-1:0]          pins;
    frame_t [CHANNELS-1:0]        frame;
  } beat_t;

endpackage

@@ hdl/smpwm_front.sv @@
// ----------------------------------------------------------------------------
// smpwm_front
// Frame counter, pending widths and mask, and the active set latched at
// every frame start.
// ----------------------------------------------------------------------------
module smpwm_front (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      accept,
  input  logic [smpwm_pkg::MODE_W-1:0]              mode,
  input  logic [smpwm_pkg::CHAN_W-1:0]              channel,
  input  logic [smpwm_pkg::VALUE_W-1:0]             value,
  input  logic [smpwm_pkg::POS_W-1:0]               frame_period,
  output smpwm_pkg::head_t                          head,
  output smpwm_pkg::width_t [smpwm_pkg::CHANNELS-1:0] active_width,
  output logic [smpwm_pkg::CHANNELS-1:0]            active_enable
);
  import smpwm_pkg::*;

  logic [POS_W-1:0]      pos;
  width_t                pending_width [CHANNELS];
  logic [CHANNELS-1:0]   pending_enable;

  logic [POS_W-1:0]      period;
  logic [POS_W-1:0]      cur;
  logic                  fs;
  logic [POS_W:0]        pos_inc;
  logic [POS_W-1:0]      pos_next;
  logic                  is_tick;
  logic                  wr_hit;
  logic [CH_W-1:0]       wr_idx;

  always_comb begin
    period   = (frame_period == '0) ? POS_W'(1) : frame_period;
    // a period lowered below the position restarts the frame
    cur      = (pos >= period) ? '0 : pos;
    fs       = (cur == '0);
    pos_inc  = {1'b0, cur} + (POS_W + 1)'(1);
    pos_next = (pos_inc >= {1'b0, period}) ? '0 : pos_inc[POS_W-1:0];
    is_tick  = (mode == MODE_TICK);
    wr_hit   = (32'(channel) < CHANNELS);
    wr_idx   = CH_W'(channel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      pending_enable <= '1;
      head           <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pending_width[c] <= RESET_WIDTH;
      end
    end else if (adv) begin
      head.valid <= accept;
      head.tick  <= accept && is_tick;
      head.fs    <= accept && is_tick && fs;
      head.pos   <= cur;
      if (accept) begin
        case (mode)
          MODE_TICK:  pos <= pos_next;
          MODE_WIDTH: begin
            if (wr_hit) pending_width[wr_idx] <= value;
          end
          MODE_MASK:  pending_enable <= value[CHANNELS-1:0];
          default:    ;
        endcase
      end
    end
  end

  // active set only matters from the first frame start on
  always_ff @(posedge clk) begin
    if (adv && accept && is_tick && fs) begin
      for (int c = 0; c < CHANNELS; c++) begin
        active_width[c] <= pending_width[c];
      end
      active_enable <= pending_enable;
    end
  end

endmodule

@@ hdl/smpwm_rank.sv @@
// ----------------------------------------------------------------------------
// smpwm_rank
// Ranks the active widths, then turns rank and width into the turn-on and
// turn-off times of every channel.
// ----------------------------------------------------------------------------
module smpwm_rank (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        adv,
  input  smpwm_pkg::head_t                            head,
  input  smpwm_pkg::width_t [smpwm_pkg::CHANNELS-1:0] active_width,
  input  logic [smpwm_pkg::CHANNELS-1:0]              active_enable,
  input  logic [smpwm_pkg::STEP_W-1:0]                stagger_step,
  output smpwm_pkg::beat_t                            beat
);
  import smpwm_pkg::*;

  rank_t               rank [CHANNELS];
  head_t               mid;
  rank_t               rank_q [CHANNELS];
  width_t              width_q [CHANNELS];
  logic [CHANNELS-1:0] en_q;
  frame_t [CHANNELS-1:0] frame;

  // rank: narrower channels first, lower index wins a tie
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rank[c] = '0;
      for (int d = 0; d < CHANNELS; d++) begin
        if (active_width[d] < active_width[c] ||
            (active_width[d] == active_width[c] && d < c)) begin
          rank[c] = rank[c] + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= '0;
    end else if (adv) begin
      mid <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rank_q[c]  <= rank[c];
        width_q[c] <= active_width[c];
      end
      en_q <= active_enable;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      frame[c].en    = en_q[c];
      frame[c].start = EDGE_W'(stagger_step) * EDGE_W'(rank_q[c]);
      frame[c].stop  = frame[c].start + EDGE_W'(width_q[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (adv) begin
      beat.valid <= mid.valid;
      beat.tick  <= mid.tick;
      beat.fs    <= mid.fs;
      beat.pos   <= mid.pos;
      beat.pins  <= '0;
      beat.frame <= frame;
    end
  end

endmodule

@@ hdl/smpwm_cell.sv @@
// ----------------------------------------------------------------------------
// smpwm_cell
// One channel: takes its window from the passing beat and sets its pin bit
// in the beat that passes on to the next cell.
// ----------------------------------------------------------------------------
module smpwm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [smpwm_pkg::CH_W-1:0]   idx,
  input  smpwm_pkg::beat_t             beat_in,
  output smpwm_pkg::beat_t             beat_out
);
  import smpwm_pkg::*;

  frame_t             use_win;
  logic [EDGE_W-1:0]  pos_ext;
  logic               hit;
  beat_t              beat_next;

  always_comb begin
    // window follows the current stagger step, so take it from every beat
    use_win   = beat_in.frame[idx];
    pos_ext   = EDGE_W'(beat_in.pos);
    hit       = use_win.en && (pos_ext >= use_win.start) && (pos_ext < use_win.stop);
    beat_next = beat_in;
    if (beat_in.tick) beat_next.pins[idx] = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out <= '0;
    end else if (adv) begin
      beat_out <= beat_next;
    end
  end

endmodule

@@ hdl/staggered_multichannel_pwm_top.sv @@
// ----------------------------------------------------------------------------
// staggered_multichannel_pwm_top
// Eight-channel servo PWM with rank-staggered turn-on times, one beat per
// clock while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / payload                       tuser
//  s_*       in   [2:0] channel, [26:3] value           [1:0] mode
//  m_*       out  [7:0] pins                            [0] frame_start
//  cfg_*     in   index 0 frame_period, 1 stagger_step  -
//
// One beat per clock, sustained while the output is not stalled; each beat
// passes the frame counter, rank, window times, one stage per channel cell
// and the output register in that order.
// A stalled output freezes the whole pipeline; s_tready is low only then.
// rst resets the counter, pending set and config and clears all beat valids at once.
// ----------------------------------------------------------------------------
module staggered_multichannel_pwm_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [smpwm_pkg::IN_DATA_W-1:0]      s_tdata,   // channel, value
  input  logic [smpwm_pkg::MODE_W-1:0]         s_tuser,   // mode
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [smpwm_pkg::OUT_DATA_W-1:0]     m_tdata,   // pins
  output logic                                 m_tuser,   // frame_start
  input  logic                                 cfg_wen,
  input  logic [smpwm_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [smpwm_pkg::REG_DATA_W-1:0]     cfg_wdata
);
  import smpwm_pkg::*;

  logic                   adv;
  logic                   accept;
  logic [POS_W-1:0]       frame_period;
  logic [STEP_W-1:0]      stagger_step;
  head_t                  head;
  width_t [CHANNELS-1:0]  active_width;
  logic [CHANNELS-1:0]    active_enable;
  beat_t                  chain [CHANNELS+1];
  beat_t                  last;
  logic [PINS_W-1:0]      pins;
  logic                   frame_start;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= RESET_PERIOD;
      stagger_step <= RESET_STEP;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_FRAME_PERIOD: frame_period <= cfg_wdata[POS_W-1:0];
        REG_STAGGER_STEP: stagger_step <= cfg_wdata[STEP_W-1:0];
        default:          ;
      endcase
    end
  end

  smpwm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .accept        (accept),
    .mode          (s_tuser),
    .channel       (s_tdata[CHAN_W-1:0]),
    .value         (s_tdata[CHAN_W +: VALUE_W]),
    .frame_period  (frame_period),
    .head          (head),
    .active_width  (active_width),
    .active_enable (active_enable)
  );

  smpwm_rank u_rank (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .head          (head),
    .active_width  (active_width),
    .active_enable (active_enable),
    .stagger_step  (stagger_step),
    .beat          (chain[0])
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    smpwm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .idx      (CH_W'(i)),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  assign last = chain[CHANNELS];

  // pins hold the last tick's levels; other items report them again
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      pins        <= '0;
      frame_start <= 1'b0;
    end else if (adv) begin
      m_tvalid    <= last.valid;
      frame_start <= last.valid && last.fs;
      if (last.valid && last.tick) pins <= PINS_W'(last.pins);
    end
  end

  assign m_tdata = OUT_DATA_W'(pins);
  assign m_tuser = frame_start;

  a_head_fs_at_zero: assert property (@(posedge clk) disable iff (rst)
    head.valid && head.fs |-> head.tick && head.pos == '0)
    else $error("frame start off position zero");

  a_fs_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    last.valid && last.fs |-> last.tick)
    else $error("frame start on a write beat");

  a_write_holds_pins: assert property (@(posedge clk) disable iff (rst)
    adv && last.valid && !last.tick |=> $stable(pins))
    else $error("write beat changed pins");

endmodule

@@ test/staggered_multichannel_pwm_top_tb.sv @@
// ----------------------------------------------------------------------------
// staggered_multichannel_pwm_top_tb
// Drives tick, width, mask and unused-code beats into the staggered servo
// PWM. A tracker keeps its own frame counter, pending set and rank order,
// and predicts pins and frame_start for every beat. Each output beat is
// compared with that prediction. Frame period and stagger step are
// rewritten between phases, and both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module staggered_multichannel_pwm_top_tb;
  import smpwm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;  // unused code, changes nothing
  localparam int ITEM_GOAL   = 1300;
  localparam int CALM_AFTER  = 1120;
  localparam int TAIL_CYCLES = CHANNELS + 12;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [MODE_W-1:0]     s_tuser   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_wen   = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  bit calm = 1'b0;
  int items_sent = 0;
  int phases = 0;

  // Frame counter, pending and active sets, ranks; queue of {frame_start, pins}
  class pwm_tracker;
    bit [POS_W-1:0]    period;
    bit [STEP_W-1:0]   step;
    int unsigned       pos;
    bit [WIDTH_W-1:0]  act_w[CHANNELS];
    bit [WIDTH_W-1:0]  pend_w[CHANNELS];
    int unsigned       rank[CHANNELS];
    bit [CHANNELS-1:0] act_en;
    bit [CHANNELS-1:0] pend_en;
    bit [CHANNELS-1:0] held;
    bit [CHANNELS:0]   pins_due[$];
    int errors;
    int checked;
    int frames;

    function new();
      period = RESET_PERIOD;
      step = RESET_STEP;
      pos = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        act_w[c] = RESET_WIDTH;
        pend_w[c] = RESET_WIDTH;
        rank[c] = c;
      end
      act_en = '1;
      pend_en = '1;
      held = '0;
      errors = 0;
      checked = 0;
      frames = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
      if (idx == REG_FRAME_PERIOD) begin
        period = val;
      end else if (idx == REG_STAGGER_STEP) begin
        step = val[STEP_W-1:0];
      end
    endfunction

    // latch pending set and order channels by width, lower index wins ties
    function void start_frame();
      for (int c = 0; c < CHANNELS; c++) act_w[c] = pend_w[c];
      act_en = pend_en;
      for (int c = 0; c < CHANNELS; c++) begin
        rank[c] = 0;
        for (int d = 0; d < CHANNELS; d++) begin
          if (act_w[d] < act_w[c] || (act_w[d] == act_w[c] && d < c)) rank[c]++;
        end
      end
    endfunction

    function void take_item(logic [MODE_W-1:0] mode, logic [CHAN_W-1:0] chan,
                            logic [VALUE_W-1:0] value);
      int unsigned per;
      int unsigned start;
      int unsigned stop;
      bit fs;
      fs = 1'b0;
      case (mode)
        MODE_TICK: begin
          per = (period == 0) ? 1 : period;
          if (pos >= per) pos = 0;
          if (pos == 0) begin
            start_frame();
            fs = 1'b1;
            frames++;
          end
          for (int c = 0; c < CHANNELS; c++) begin
            start = step * rank[c];
            stop = start + act_w[c];
            held[c] = act_en[c] && pos >= start && pos < stop;
          end
          pos++;
          if (pos >= per) pos = 0;
        end
        MODE_WIDTH: begin
          if (chan < CHANNELS) pend_w[chan] = value;
        end
        MODE_MASK: begin
          pend_en = value[CHANNELS-1:0];
        end
        default: ;
      endcase
      pins_due.push_back({fs, held});
    endfunction

    function void match_pins(logic [OUT_DATA_W-1:0] pins, logic fs);
      bit [CHANNELS:0] due;
      if (pins_due.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing due: pins=%02h frame_start=%b", $time, pins, fs);
        return;
      end
      due = pins_due.pop_front();
      checked++;
      if (pins !== due[CHANNELS-1:0]) begin
        errors++;
        $display("%0t: pins expected %02h actual %02h", $time, due[CHANNELS-1:0], pins);
      end
      if (fs !== due[CHANNELS]) begin
        errors++;
        $display("%0t: frame_start expected %b actual %b", $time, due[CHANNELS], fs);
      end
    endfunction
  endclass

  pwm_tracker trk;

  staggered_multichannel_pwm_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) trk.match_pins(m_tdata, m_tuser);
  end

  // receiver: stall in bursts until the calm tail
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 8);
      end
      m_tready <= (stall == 0);
    end
  end

  task automatic send_beat(logic [MODE_W-1:0] mode, logic [CHAN_W-1:0] chan,
                           logic [VALUE_W-1:0] value);
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {{(IN_DATA_W - CHAN_W - VALUE_W){1'b0}}, value, chan};
    do @(posedge clk); while (!s_tready);
    trk.take_item(mode, chan, value);
    items_sent++;
  endtask

  // drop valid and wait for every due beat to come out
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (trk.pins_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    trk.set_reg(idx, val);
  endtask

  task automatic tick();
    logic [31:0] r;
    r = $urandom;
    send_beat(MODE_TICK, r[2:0], r[31:8]);
  endtask

  task automatic random_beat(int unsigned span);
    logic [31:0] r;
    logic [VALUE_W-1:0] w;
    int unsigned pick;
    r = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_beat(MODE_TICK, r[2:0], r[31:8]);
    end else if (pick < 88) begin
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = '1;
        2: w = r[31:8];
        default: w = VALUE_W'($urandom_range(0, span));
      endcase
      send_beat(MODE_WIDTH, r[2:0], w);
    end else if (pick < 96) begin
      w = ($urandom_range(0, 3) == 0) ? '1 : r[31:8];
      send_beat(MODE_MASK, r[2:0], w);
    end else begin
      send_beat(MODE_NONE, r[2:0], r[31:8]);
    end
  endtask

  initial begin
    logic [POS_W-1:0] per;
    logic [STEP_W-1:0] stp;
    int len;
    int unsigned span;
    trk = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: frame starts on the first tick, ranks follow channel order
    repeat (3) tick();
    send_beat(MODE_WIDTH, 3'd7, 24'd0);
    send_beat(MODE_WIDTH, 3'd0, 24'hFFFFFF);
    send_beat(MODE_WIDTH, 3'd1, 24'd2);
    send_beat(MODE_WIDTH, 3'd2, 24'd2);         // tie with channel 1
    send_beat(MODE_MASK, 3'd7, 24'hFFFF5A);     // bits above the channels drop
    send_beat(MODE_NONE, 3'd7, 24'hFFFFFF);
    tick();

    // short frames: pending set latches, zero width stays low
    write_reg(REG_FRAME_PERIOD, 24'd4);
    write_reg(REG_STAGGER_STEP, 24'd1);
    repeat (6) tick();

    // zero period acts as one: every tick starts a frame
    write_reg(REG_FRAME_PERIOD, 24'd0);
    write_reg(REG_STAGGER_STEP, 24'hFFFF);
    send_beat(MODE_MASK, 3'd0, 24'hFFFFFF);
    repeat (2) tick();

    write_reg(REG_FRAME_PERIOD, 24'hFFFFFF);
    repeat (3) tick();

    // period now below the position: next tick restarts the frame
    write_reg(REG_FRAME_PERIOD, 24'd2);
    write_reg(REG_STAGGER_STEP, 24'd0);
    repeat (3) tick();

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 11))
        0: per = '0;
        1: per = 24'd1;
        2: per = '1;
        default: per = POS_W'($urandom_range(2, 48));
      endcase
      case ($urandom_range(0, 7))
        0: stp = '0;
        1: stp = '1;
        2: stp = STEP_W'($urandom_range(0, 65535));
        default: stp = STEP_W'($urandom_range(1, 6));
      endcase
      write_reg(REG_FRAME_PERIOD, per);
      write_reg(REG_STAGGER_STEP, {8'd0, stp});
      phases++;
      span = ((per > 60) ? 60 : per) + 4;
      len = $urandom_range(60, 140);
      for (int i = 0; i < len; i++) begin
        if (items_sent >= CALM_AFTER) calm = 1'b1;
        random_beat(span);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d beats over %0d random settings; %0d results checked, %0d frames.",
             items_sent, phases, trk.checked, trk.frames);
    if (trk.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d results still due.", trk.pins_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ staggered_multichannel_pwm_top.f @@
hdl/smpwm_pkg.sv
hdl/smpwm_front.sv
hdl/smpwm_rank.sv
hdl/smpwm_cell.sv
hdl/staggered_multichannel_pwm_top.sv
test/staggered_multichannel_pwm_top_tb.sv
